>>> design/pcsp_pkg.sv
package pcsp_pkg;

    // Default station cap per segment.
    localparam int unsigned MAX_STATIONS_DEF = 64;

    // Binary point of the unit direction vector (Q2.30).
    localparam int unsigned UNIT_BITS = 30;

    // Configuration register indexes.
    localparam logic [2:0] REG_SPACING     = 3'd0;
    localparam logic [2:0] REG_HALF_LENGTH = 3'd1;
    localparam logic [2:0] REG_XMIN        = 3'd2;
    localparam logic [2:0] REG_XMAX        = 3'd3;
    localparam logic [2:0] REG_YMIN        = 3'd4;
    localparam logic [2:0] REG_YMAX        = 3'd5;

    // Configuration reset values.
    localparam logic [30:0] SPACING_RST     = 31'd655360;
    localparam logic [30:0] HALF_LENGTH_RST = 31'd655360;
    localparam logic [31:0] EXT_MIN_RST     = 32'h8000_0000;
    localparam logic [31:0] EXT_MAX_RST     = 32'h7FFF_FFFF;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic [30:0]        spacing;
        logic [30:0]        half_length;
        logic signed [31:0] xmin;
        logic signed [31:0] xmax;
        logic signed [31:0] ymin;
        logic signed [31:0] ymax;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc;
        logic sq_a;
        logic sq_b;
        logic sqrt_init;
        logic sqrt_step;
        logic len_chk;
        logic div_step;
        logic k_fin;
        logic x_fin;
        logic y_fin;
        logic off_x;
        logic off_y;
        logic st_x;
        logic st_y;
        logic chk;
        logic fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic first;
        logic iter_last;
        logic len_stop;
        logic in_ext;
        logic pend_valid;
        logic out_free;
        logic more;
    } t_sts;

endpackage

>>> design/pcsp_ifs.sv
// Vertex channel.
interface pcsp_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               part_start;
    logic [15:0]        line_index;
    logic [7:0]         part_index;

    modport source (output valid, vertex_x, vertex_y, part_start, line_index, part_index,
                    input ready);
    modport sink (input valid, vertex_x, vertex_y, part_start, line_index, part_index,
                  output ready);
endinterface

// Transect channel.
interface pcsp_tr_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_x;
    logic signed [31:0] left_y;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic [31:0]        profile_number;
    logic [15:0]        line_tag;
    logic [7:0]         part_tag;
    logic               last_of_run;
    logic               truncated;

    modport source (output valid, left_x, left_y, right_x, right_y, profile_number,
                    line_tag, part_tag, last_of_run, truncated, input ready);
    modport sink (input valid, left_x, left_y, right_x, right_y, profile_number,
                  line_tag, part_tag, last_of_run, truncated, output ready);
endinterface

>>> design/pcsp_dp.sv
module pcsp_dp #(
    parameter int unsigned MAX_STATIONS = pcsp_pkg::MAX_STATIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcsp_pkg::t_cfg     i_cfg,
    input  pcsp_pkg::t_cmd     i_cmd,
    output pcsp_pkg::t_sts     o_sts,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic               i_part_start,
    input  logic [15:0]        i_line_index,
    input  logic [7:0]         i_part_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_left_x,
    output logic signed [31:0] o_left_y,
    output logic signed [31:0] o_right_x,
    output logic signed [31:0] o_right_y,
    output logic [31:0]        o_profile_number,
    output logic [15:0]        o_line_tag,
    output logic [7:0]         o_part_tag,
    output logic               o_last_of_run,
    output logic               o_truncated
);

    localparam int unsigned IW = $clog2(MAX_STATIONS + 1);
    localparam int unsigned UB = pcsp_pkg::UNIT_BITS;
    localparam int unsigned DIV_ITERS = 62;
    localparam int unsigned SQRT_ITERS = 32;

    // floor(sign * mag / 2^UB) for a product magnitude below 2^63.
    function automatic logic signed [34:0] f_scale(input logic [64:0] mag, input logic neg);
        logic [64:0] adj;
        logic [33:0] sh;
        adj = neg ? mag + ((65'd1 << UB) - 65'd1) : mag;
        sh  = adj[UB+33:UB];
        return neg ? -$signed({1'b0, sh}) : $signed({1'b0, sh});
    endfunction

    // Saturate to the signed 32 bit range.
    function automatic logic [31:0] f_sat(input logic signed [35:0] v);
        logic [31:0] res;
        if (v > 36'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Vertex and segment state.
    logic signed [31:0] r_px, r_py, r_sx, r_sy;
    logic               r_have;
    logic [30:0]        r_carry;
    logic [31:0]        r_prof;
    logic [31:0]        r_ax, r_ay;
    logic               r_xn, r_yn;
    logic [15:0]        r_ltag;
    logic [7:0]         r_ptag;
    logic [64:0]        r_s;
    // Square root unit.
    logic [63:0]        r_op, r_res, r_bit;
    logic               r_big;
    // Divider unit.
    logic [32:0]        r_rem, r_dvs;
    logic [61:0]        r_quo;
    logic [5:0]         r_iter;
    // Station stepping.
    logic [32:0]        r_len;
    logic               r_trunc;
    logic [33:0]        r_t;
    logic [IW-1:0]      r_i;
    logic [30:0]        r_uxm, r_uym;
    logic signed [32:0] r_ox, r_oy;
    logic signed [34:0] r_cx, r_cy;
    // Pending transect, held until it is known whether another follows.
    logic               r_pv;
    logic [31:0]        r_plx, r_ply, r_prx, r_pry, r_pnum;
    // Output register.
    logic               r_ov;
    logic [31:0]        r_olx, r_oly, r_orx, r_ory, r_onum;
    logic [15:0]        r_oltag;
    logic [7:0]         r_optag;
    logic               r_olast, r_otrunc;

    logic signed [32:0] dx, dy;
    logic [32:0]        adx, ady;
    logic [32:0]        mul_a;
    logic [31:0]        mul_b;
    logic [64:0]        prod;
    logic [63:0]        trial;
    logic [32:0]        len;
    logic [30:0]        step;
    logic [33:0]        rem2;
    logic               ge;
    logic signed [34:0] sxe, sye;
    logic               in_ext;
    logic [31:0]        lx, ly, rx, ry;
    logic [33:0]        t_next;
    logic               out_free;
    logic               kz;

    assign step = (i_cfg.spacing == 31'd0) ? 31'd1 : i_cfg.spacing;

    // Difference to the previous vertex.
    assign dx  = $signed({i_vertex_x[31], i_vertex_x}) - $signed({r_px[31], r_px});
    assign dy  = $signed({i_vertex_y[31], i_vertex_y}) - $signed({r_py[31], r_py});
    assign adx = dx[32] ? 33'(-dx) : 33'(dx);
    assign ady = dy[32] ? 33'(-dy) : 33'(dy);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        priority if (i_cmd.sq_a) begin
            mul_a = {1'b0, r_ax};
            mul_b = r_ax;
        end else if (i_cmd.sq_b) begin
            mul_a = {1'b0, r_ay};
            mul_b = r_ay;
        end else if (i_cmd.off_x) begin
            mul_a = {2'b0, i_cfg.half_length};
            mul_b = {1'b0, r_uxm};
        end else if (i_cmd.off_y) begin
            mul_a = {2'b0, i_cfg.half_length};
            mul_b = {1'b0, r_uym};
        end else if (i_cmd.st_x) begin
            mul_a = r_t[32:0];
            mul_b = {1'b0, r_uxm};
        end else if (i_cmd.st_y) begin
            mul_a = r_t[32:0];
            mul_b = {1'b0, r_uym};
        end
    end
    assign prod = 65'(mul_a * mul_b);

    // Square root and divider steps.
    assign trial = r_res + r_bit;
    assign len   = r_big ? {r_res[31:0], 1'b0} : {1'b0, r_res[31:0]};
    assign rem2  = {r_rem, r_quo[61]};
    assign ge    = rem2 >= {1'b0, r_dvs};
    assign kz    = (r_rem == 33'd0);

    // Station extent test and transect endpoints.
    assign sxe    = $signed({{3{r_sx[31]}}, r_sx});
    assign sye    = $signed({{3{r_sy[31]}}, r_sy});
    assign in_ext = (r_cx >= $signed({{3{i_cfg.xmin[31]}}, i_cfg.xmin}))
                 && (r_cx <= $signed({{3{i_cfg.xmax[31]}}, i_cfg.xmax}))
                 && (r_cy >= $signed({{3{i_cfg.ymin[31]}}, i_cfg.ymin}))
                 && (r_cy <= $signed({{3{i_cfg.ymax[31]}}, i_cfg.ymax}));
    assign lx = f_sat($signed({r_cx[34], r_cx}) + $signed({{3{r_oy[32]}}, r_oy}));
    assign ly = f_sat($signed({r_cy[34], r_cy}) - $signed({{3{r_ox[32]}}, r_ox}));
    assign rx = f_sat($signed({r_cx[34], r_cx}) - $signed({{3{r_oy[32]}}, r_oy}));
    assign ry = f_sat($signed({r_cy[34], r_cy}) + $signed({{3{r_ox[32]}}, r_ox}));
    assign t_next   = r_t + {3'b0, step};
    assign out_free = !r_ov || i_ready;

    // Status to the controller.
    always_comb begin
        o_sts.first      = i_part_start || !r_have;
        o_sts.iter_last  = (r_iter == 6'd0);
        o_sts.len_stop   = (len == 33'd0) || ({2'b0, r_carry} >= len);
        o_sts.in_ext     = in_ext;
        o_sts.pend_valid = r_pv;
        o_sts.out_free   = out_free;
        o_sts.more       = (({1'b0, r_i} + 1'b1) < (IW+1)'(MAX_STATIONS))
                        && (t_next < {1'b0, r_len});
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px    <= '0;
            r_py    <= '0;
            r_have  <= 1'b0;
            r_carry <= '0;
            r_prof  <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_px <= i_vertex_x;
                r_py <= i_vertex_y;
                if (o_sts.first) begin
                    r_have  <= 1'b1;
                    r_carry <= '0;
                end
            end
            if (i_cmd.len_chk && len != 33'd0 && {2'b0, r_carry} >= len) begin
                r_carry <= 31'({2'b0, r_carry} - len);
            end
            if (i_cmd.k_fin) begin
                r_carry <= kz ? 31'd0 : 31'({2'b0, step} - r_rem);
            end
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.chk && in_ext) begin
                r_prof <= r_prof + 32'd1;
                r_pv   <= 1'b1;
                if (r_pv) begin
                    r_ov <= 1'b1;
                end
            end
            if (i_cmd.fin && r_pv) begin
                r_pv <= 1'b0;
                r_ov <= 1'b1;
            end
        end
    end

    // Payload and arithmetic registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_sx   <= r_px;
            r_sy   <= r_py;
            r_ax   <= adx[31:0];
            r_ay   <= ady[31:0];
            r_xn   <= dx[32];
            r_yn   <= dy[32];
            r_ltag <= i_line_index;
            r_ptag <= i_part_index;
        end
        if (i_cmd.sq_a) begin
            r_s <= prod;
        end
        if (i_cmd.sq_b) begin
            r_s <= r_s + prod;
        end
        if (i_cmd.sqrt_init) begin
            r_op   <= r_s[64] ? {1'b0, r_s[64:2]} : r_s[63:0];
            r_res  <= '0;
            r_bit  <= 64'd1 << 62;
            r_big  <= r_s[64];
            r_iter <= 6'(SQRT_ITERS - 1);
        end
        if (i_cmd.sqrt_step) begin
            if (r_op >= trial) begin
                r_op  <= r_op - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit  <= r_bit >> 2;
            r_iter <= r_iter - 6'd1;
        end
        // Station count division: (len - carry) / step.
        if (i_cmd.len_chk) begin
            r_len  <= len;
            r_t    <= {3'b0, r_carry};
            r_quo  <= {29'b0, 33'(len - {2'b0, r_carry})};
            r_rem  <= '0;
            r_dvs  <= {2'b0, step};
            r_iter <= 6'(DIV_ITERS - 1);
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? 33'(rem2 - {1'b0, r_dvs}) : rem2[32:0];
            r_quo  <= {r_quo[60:0], ge};
            r_iter <= r_iter - 6'd1;
        end
        // Cap check, then the x component of the unit vector.
        if (i_cmd.k_fin) begin
            r_trunc <= (r_quo > 62'(MAX_STATIONS))
                    || ((r_quo == 62'(MAX_STATIONS)) && !kz);
            r_i     <= '0;
            r_quo   <= {r_ax, 30'b0};
            r_rem   <= '0;
            r_dvs   <= r_len;
            r_iter  <= 6'(DIV_ITERS - 1);
        end
        if (i_cmd.x_fin) begin
            r_uxm  <= r_quo[30:0];
            r_quo  <= {r_ay, 30'b0};
            r_rem  <= '0;
            r_iter <= 6'(DIV_ITERS - 1);
        end
        if (i_cmd.y_fin) begin
            r_uym <= r_quo[30:0];
        end
        if (i_cmd.off_x) begin
            r_ox <= 33'(f_scale(prod, r_xn));
        end
        if (i_cmd.off_y) begin
            r_oy <= 33'(f_scale(prod, r_yn));
        end
        if (i_cmd.st_x) begin
            r_cx <= sxe + f_scale(prod, r_xn);
        end
        if (i_cmd.st_y) begin
            r_cy <= sye + f_scale(prod, r_yn);
        end
        // Station commit; in extent, old pending goes out, new one waits.
        if (i_cmd.chk) begin
            r_t <= t_next;
            r_i <= r_i + 1'b1;
            if (in_ext) begin
                r_plx  <= lx;
                r_ply  <= ly;
                r_prx  <= rx;
                r_pry  <= ry;
                r_pnum <= r_prof + 32'd1;
                if (r_pv) begin
                    r_olx    <= r_plx;
                    r_oly    <= r_ply;
                    r_orx    <= r_prx;
                    r_ory    <= r_pry;
                    r_onum   <= r_pnum;
                    r_oltag  <= r_ltag;
                    r_optag  <= r_ptag;
                    r_olast  <= 1'b0;
                    r_otrunc <= r_trunc;
                end
            end
        end
        if (i_cmd.fin && r_pv) begin
            r_olx    <= r_plx;
            r_oly    <= r_ply;
            r_orx    <= r_prx;
            r_ory    <= r_pry;
            r_onum   <= r_pnum;
            r_oltag  <= r_ltag;
            r_optag  <= r_ptag;
            r_olast  <= 1'b1;
            r_otrunc <= r_trunc;
        end
    end

    assign o_valid          = r_ov;
    assign o_left_x         = r_olx;
    assign o_left_y         = r_oly;
    assign o_right_x        = r_orx;
    assign o_right_y        = r_ory;
    assign o_profile_number = r_onum;
    assign o_line_tag       = r_oltag;
    assign o_part_tag       = r_optag;
    assign o_last_of_run    = r_olast;
    assign o_truncated      = r_otrunc;

endmodule

>>> design/pcsp_ctrl.sv
module pcsp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pcsp_pkg::t_sts i_sts,
    output pcsp_pkg::t_cmd o_cmd
);

    typedef enum logic [17:0] {
        S_IDLE = 18'b000000000000000001,
        S_SQA  = 18'b000000000000000010,
        S_SQB  = 18'b000000000000000100,
        S_SQI  = 18'b000000000000001000,
        S_SQRT = 18'b000000000000010000,
        S_LEN  = 18'b000000000000100000,
        S_DIVK = 18'b000000000001000000,
        S_KFIN = 18'b000000000010000000,
        S_DIVX = 18'b000000000100000000,
        S_XFIN = 18'b000000001000000000,
        S_DIVY = 18'b000000010000000000,
        S_YFIN = 18'b000000100000000000,
        S_OFFX = 18'b000001000000000000,
        S_OFFY = 18'b000010000000000000,
        S_STX  = 18'b000100000000000000,
        S_STY  = 18'b001000000000000000,
        S_CHK  = 18'b010000000000000000,
        S_FIN  = 18'b100000000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.acc = 1'b1;
                    if (!i_sts.first) begin
                        n_state = S_SQA;
                    end
                end
            end
            S_SQA: begin
                o_cmd.sq_a = 1'b1;
                n_state    = S_SQB;
            end
            S_SQB: begin
                o_cmd.sq_b = 1'b1;
                n_state    = S_SQI;
            end
            S_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.iter_last) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.len_chk = 1'b1;
                n_state       = i_sts.len_stop ? S_IDLE : S_DIVK;
            end
            S_DIVK: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.iter_last) begin
                    n_state = S_KFIN;
                end
            end
            S_KFIN: begin
                o_cmd.k_fin = 1'b1;
                n_state     = S_DIVX;
            end
            S_DIVX: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.iter_last) begin
                    n_state = S_XFIN;
                end
            end
            S_XFIN: begin
                o_cmd.x_fin = 1'b1;
                n_state     = S_DIVY;
            end
            S_DIVY: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.iter_last) begin
                    n_state = S_YFIN;
                end
            end
            S_YFIN: begin
                o_cmd.y_fin = 1'b1;
                n_state     = S_OFFX;
            end
            S_OFFX: begin
                o_cmd.off_x = 1'b1;
                n_state     = S_OFFY;
            end
            S_OFFY: begin
                o_cmd.off_y = 1'b1;
                n_state     = S_STX;
            end
            S_STX: begin
                o_cmd.st_x = 1'b1;
                n_state    = S_STY;
            end
            S_STY: begin
                o_cmd.st_y = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                // Hold while an older transect must leave but the output is full.
                if (!(i_sts.in_ext && i_sts.pend_valid && !i_sts.out_free)) begin
                    o_cmd.chk = 1'b1;
                    n_state   = i_sts.more ? S_STX : S_FIN;
                end
            end
            S_FIN: begin
                if (!(i_sts.pend_valid && !i_sts.out_free)) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/polyline_cross_section_placer.sv
// A first vertex, or one that starts a part, is only stored and gives nothing; a zero-length
// segment, or one that ends within the carried distance, stops after the square root.
// Any other vertex runs a 32 step square root and three 62 step divisions on one shared
// divider, then steps through its stations, waiting whenever the output stalls.
// Throughput: one vertex at a time; the next is accepted once the segment is finished.
// Reset (synchronous, active low) clears segment state and output, restores config defaults.
module polyline_cross_section_placer #(
    parameter int unsigned MAX_STATIONS_PER_SEGMENT = pcsp_pkg::MAX_STATIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcsp_vtx_if.sink    i_vtx,
    pcsp_tr_if.source   o_tr,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pcsp_pkg::t_cfg r_cfg;
    pcsp_pkg::t_cmd cmd;
    pcsp_pkg::t_sts sts;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spacing     <= pcsp_pkg::SPACING_RST;
            r_cfg.half_length <= pcsp_pkg::HALF_LENGTH_RST;
            r_cfg.xmin        <= pcsp_pkg::EXT_MIN_RST;
            r_cfg.xmax        <= pcsp_pkg::EXT_MAX_RST;
            r_cfg.ymin        <= pcsp_pkg::EXT_MIN_RST;
            r_cfg.ymax        <= pcsp_pkg::EXT_MAX_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                pcsp_pkg::REG_SPACING:     r_cfg.spacing     <= pwdata[30:0];
                pcsp_pkg::REG_HALF_LENGTH: r_cfg.half_length <= pwdata[30:0];
                pcsp_pkg::REG_XMIN:        r_cfg.xmin        <= pwdata;
                pcsp_pkg::REG_XMAX:        r_cfg.xmax        <= pwdata;
                pcsp_pkg::REG_YMIN:        r_cfg.ymin        <= pwdata;
                pcsp_pkg::REG_YMAX:        r_cfg.ymax        <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (reg_idx)
            pcsp_pkg::REG_SPACING:     prdata = {1'b0, r_cfg.spacing};
            pcsp_pkg::REG_HALF_LENGTH: prdata = {1'b0, r_cfg.half_length};
            pcsp_pkg::REG_XMIN:        prdata = r_cfg.xmin;
            pcsp_pkg::REG_XMAX:        prdata = r_cfg.xmax;
            pcsp_pkg::REG_YMIN:        prdata = r_cfg.ymin;
            pcsp_pkg::REG_YMAX:        prdata = r_cfg.ymax;
            default:                   prdata = '0;
        endcase
    end

    pcsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vtx.valid),
        .o_ready (i_vtx.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pcsp_dp #(
        .MAX_STATIONS (MAX_STATIONS_PER_SEGMENT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_vertex_x       (i_vtx.vertex_x),
        .i_vertex_y       (i_vtx.vertex_y),
        .i_part_start     (i_vtx.part_start),
        .i_line_index     (i_vtx.line_index),
        .i_part_index     (i_vtx.part_index),
        .o_valid          (o_tr.valid),
        .i_ready          (o_tr.ready),
        .o_left_x         (o_tr.left_x),
        .o_left_y         (o_tr.left_y),
        .o_right_x        (o_tr.right_x),
        .o_right_y        (o_tr.right_y),
        .o_profile_number (o_tr.profile_number),
        .o_line_tag       (o_tr.line_tag),
        .o_part_tag       (o_tr.part_tag),
        .o_last_of_run    (o_tr.last_of_run),
        .o_truncated      (o_tr.truncated)
    );

endmodule

>>> dv/polyline_cross_section_placer_checker.sv
module polyline_cross_section_placer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcsp_vtx_if         vtx,
    pcsp_tr_if          tr,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_transects
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STATION_CAP = pcsp_pkg::MAX_STATIONS_DEF;

    typedef struct {
        logic signed [31:0] left_x;
        logic signed [31:0] left_y;
        logic signed [31:0] right_x;
        logic signed [31:0] right_y;
        logic [31:0]        profile_number;
        logic [15:0]        line_tag;
        logic [7:0]         part_tag;
        logic               last_of_run;
        logic               truncated;
    } t_transect;

    t_transect expected_transects[$];

    // Shadow copy of the configuration registers.
    logic [30:0]        cfg_spacing;
    logic [30:0]        cfg_half;
    logic signed [31:0] cfg_xmin, cfg_xmax, cfg_ymin, cfg_ymax;

    // Shadow copy of the segment state.
    longint             last_x, last_y;
    longint unsigned    carry;
    logic               seen_vertex;
    logic [31:0]        profile_count;

    assign o_pending = expected_transects.size();

    function automatic longint unsigned int_sqrt(input longint unsigned op);
        longint unsigned res, b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > op) b = b >> 2;
        while (b != 0) begin
            if (op >= res + b) begin
                op = op - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Floor of a signed Q2.30 product back to Q16.16.
    function automatic longint unit_scale(input longint unsigned mag, input logic neg);
        if (neg) return -longint'((mag + ((64'd1 << pcsp_pkg::UNIT_BITS) - 1))
                                  >> pcsp_pkg::UNIT_BITS);
        return longint'(mag >> pcsp_pkg::UNIT_BITS);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Works out the transects that one vertex produces.
    task automatic place_stations(input logic signed [31:0] x, input logic signed [31:0] y,
                                  input logic start, input logic [15:0] li,
                                  input logic [7:0] pi);
        longint          dx, dy, px, py, cx, cy, ox, oy;
        longint unsigned ax, ay, a2, b2, s, len, stride, d0, ktot, uxm, uym, t;
        logic            trunc;
        int              n, i;
        t_transect       tr_item;
        px = last_x;
        py = last_y;
        last_x = longint'(x);
        last_y = longint'(y);
        if (start || !seen_vertex) begin
            seen_vertex = 1'b1;
            carry = 0;
            return;
        end
        dx = longint'(x) - px;
        dy = longint'(y) - py;
        ax = (dx < 0) ? longint'(-dx) : dx;
        ay = (dy < 0) ? longint'(-dy) : dy;
        a2 = ax * ax;
        b2 = ay * ay;
        s = a2 + b2;
        // The sum of squares can wrap for the longest diagonals.
        if (s < a2) len = 2 * int_sqrt((s >> 2) | (64'd1 << 62));
        else len = int_sqrt(s);
        if (len == 0) return;
        stride = (cfg_spacing == 0) ? 1 : cfg_spacing;
        d0 = carry;
        if (d0 >= len) begin
            carry = d0 - len;
            return;
        end
        ktot = (len - d0 + stride - 1) / stride;
        carry = d0 + ktot * stride - len;
        trunc = ktot > STATION_CAP;
        uxm = (ax << pcsp_pkg::UNIT_BITS) / len;
        uym = (ay << pcsp_pkg::UNIT_BITS) / len;
        ox = unit_scale(cfg_half * uxm, dx < 0);
        oy = unit_scale(cfg_half * uym, dy < 0);
        n = 0;
        t = d0;
        for (i = 0; i < STATION_CAP && t < len; i++) begin
            cx = px + unit_scale(t * uxm, dx < 0);
            cy = py + unit_scale(t * uym, dy < 0);
            t = t + stride;
            if (cx < cfg_xmin || cx > cfg_xmax || cy < cfg_ymin || cy > cfg_ymax) continue;
            profile_count = profile_count + 1;
            tr_item.left_x = clamp32(cx + oy);
            tr_item.left_y = clamp32(cy - ox);
            tr_item.right_x = clamp32(cx - oy);
            tr_item.right_y = clamp32(cy + ox);
            tr_item.profile_number = profile_count;
            tr_item.line_tag = li;
            tr_item.part_tag = pi;
            tr_item.last_of_run = 1'b0;
            tr_item.truncated = trunc;
            expected_transects.push_back(tr_item);
            n++;
        end
        if (n > 0) expected_transects[expected_transects.size() - 1].last_of_run = 1'b1;
    endtask

    function automatic void check_field(input string name, input longint unsigned exp_v,
                                        input longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            o_errors++;
        end
    endfunction

    // Track configuration writes, vertex transactions and transect transactions.
    always @(posedge i_clk) begin
        t_transect want;
        if (!i_rst_n) begin
            cfg_spacing <= pcsp_pkg::SPACING_RST;
            cfg_half <= pcsp_pkg::HALF_LENGTH_RST;
            cfg_xmin <= pcsp_pkg::EXT_MIN_RST;
            cfg_xmax <= pcsp_pkg::EXT_MAX_RST;
            cfg_ymin <= pcsp_pkg::EXT_MIN_RST;
            cfg_ymax <= pcsp_pkg::EXT_MAX_RST;
            last_x = 0;
            last_y = 0;
            carry = 0;
            seen_vertex = 1'b0;
            profile_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    pcsp_pkg::REG_SPACING:     cfg_spacing <= pwdata[30:0];
                    pcsp_pkg::REG_HALF_LENGTH: cfg_half <= pwdata[30:0];
                    pcsp_pkg::REG_XMIN:        cfg_xmin <= pwdata;
                    pcsp_pkg::REG_XMAX:        cfg_xmax <= pwdata;
                    pcsp_pkg::REG_YMIN:        cfg_ymin <= pwdata;
                    pcsp_pkg::REG_YMAX:        cfg_ymax <= pwdata;
                    default: ;
                endcase
            end
            if (vtx.valid && vtx.ready)
                place_stations(vtx.vertex_x, vtx.vertex_y, vtx.part_start,
                               vtx.line_index, vtx.part_index);
            if (tr.valid && tr.ready) begin
                o_transects++;
                if (expected_transects.size() == 0) begin
                    $error("unexpected transect, profile_number %0d", tr.profile_number);
                    o_errors++;
                end else begin
                    want = expected_transects.pop_front();
                    check_field("left_x", want.left_x, tr.left_x);
                    check_field("left_y", want.left_y, tr.left_y);
                    check_field("right_x", want.right_x, tr.right_x);
                    check_field("right_y", want.right_y, tr.right_y);
                    check_field("profile_number", want.profile_number, tr.profile_number);
                    check_field("line_tag", want.line_tag, tr.line_tag);
                    check_field("part_tag", want.part_tag, tr.part_tag);
                    check_field("last_of_run", want.last_of_run, tr.last_of_run);
                    check_field("truncated", want.truncated, tr.truncated);
                end
            end
        end
    end

    initial begin
        o_errors = 0;
        o_transects = 0;
    end
endmodule

>>> dv/polyline_cross_section_placer_test.sv
module polyline_cross_section_placer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending, transects;
    int          vertices_sent = 0;
    int          settings_used = 0;
    logic        no_idle = 1'b0;
    logic        hold_go = 1'b0;
    int          hold_left = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;

    pcsp_vtx_if vtx ();
    pcsp_tr_if  tr ();

    polyline_cross_section_placer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vtx(vtx.sink), .o_tr(tr.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    polyline_cross_section_placer_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .vtx(vtx), .tr(tr),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .o_errors(errors), .o_pending(pending), .o_transects(transects)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        vtx.valid = 1'b0;
        vtx.vertex_x = '0;
        vtx.vertex_y = '0;
        vtx.part_start = 1'b0;
        vtx.line_index = '0;
        vtx.part_index = '0;
        tr.ready = 1'b0;
    end

    // Transect receiver: random stall bursts, one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left = 400;
            hold_go = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            tr.ready <= 1'b0;
        end else if (no_idle) begin
            tr.ready <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            tr.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 7);
            tr.ready <= 1'b0;
        end else begin
            tr.ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((vtx.valid && vtx.ready) || (tr.valid && tr.ready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL polyline_cross_section_placer");
            $finish;
        end
    end

    // A setup phase, then an access phase.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Stops offering vertices, waits for every transect, then lets a silent segment finish.
    task automatic drain();
        vtx.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [30:0] sp, input logic [30:0] half,
                                input logic [31:0] x0, input logic [31:0] x1,
                                input logic [31:0] y0, input logic [31:0] y1);
        drain();
        reg_write(pcsp_pkg::REG_SPACING, {1'b0, sp});
        reg_write(pcsp_pkg::REG_HALF_LENGTH, {1'b0, half});
        reg_write(pcsp_pkg::REG_XMIN, x0);
        reg_write(pcsp_pkg::REG_XMAX, x1);
        reg_write(pcsp_pkg::REG_YMIN, y0);
        reg_write(pcsp_pkg::REG_YMAX, y1);
        settings_used++;
    endtask

    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic start, input logic [15:0] li,
                               input logic [7:0] pi);
        vtx.valid <= 1'b1;
        vtx.vertex_x <= x;
        vtx.vertex_y <= y;
        vtx.part_start <= start;
        vtx.line_index <= li;
        vtx.part_index <= pi;
        do @(posedge i_clk); while (!vtx.ready);
        vertices_sent++;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            vtx.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // A random part: a start vertex and a walk of steps up to reach in each axis,
    // with an occasional repeated or far-flung vertex mixed in.
    task automatic random_part(input int count, input int unsigned reach,
                               input int unsigned around);
        logic [31:0] x, y;
        logic [15:0] li;
        logic [7:0]  pi;
        int          k;
        li = 16'($urandom());
        pi = 8'($urandom());
        if ($urandom_range(0, 7) == 0) begin
            x = $urandom();
            y = $urandom();
        end else begin
            x = $urandom_range(0, 2 * around) - around;
            y = $urandom_range(0, 2 * around) - around;
        end
        send_vertex(x, y, 1'b1, li, pi);
        for (k = 1; k < count; k++) begin
            case ($urandom_range(0, 19))
                0: ;
                1: begin
                    x = $urandom();
                    y = $urandom();
                end
                default: begin
                    x = x + $urandom_range(0, 2 * reach) - reach;
                    y = y + $urandom_range(0, 2 * reach) - reach;
                end
            endcase
            send_vertex(x, y, ($urandom_range(0, 30) == 0), li, pi);
        end
    endtask

    initial begin
        int unsigned sp;
        int          ph;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default settings, first vertex, zero-length, extremes of direction.
        send_vertex(32'd0, 32'd0, 1'b0, 16'hFFFF, 8'hFF);
        send_vertex(32'd0, 32'd0, 1'b0, 16'h0000, 8'h00);
        send_vertex(32'h0032_0000, 32'd0, 1'b0, 16'h1234, 8'h56);
        send_vertex(32'h0032_0000, 32'hFFCE_0000, 1'b0, 16'h1234, 8'h56);
        send_vertex(32'hFFE0_0000, 32'h0010_0000, 1'b0, 16'h1234, 8'h57);
        send_vertex(32'h8000_0000, 32'h8000_0000, 1'b1, 16'hFFFF, 8'hFF);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'hFFFF, 8'hFF);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 16'h0001, 8'h01);
        send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0, 16'h0002, 8'h02);
        send_vertex(32'h0000_0001, 32'h0000_0001, 1'b1, 16'h0003, 8'h03);
        send_vertex(32'h0000_0002, 32'h0000_0002, 1'b0, 16'h0003, 8'h03);

        // Zero spacing behaves as one: the nonzero-length segment hits the station cap.
        set_geometry(31'd0, 31'h7FFF_FFFF, pcsp_pkg::EXT_MIN_RST, pcsp_pkg::EXT_MAX_RST,
                     pcsp_pkg::EXT_MIN_RST, pcsp_pkg::EXT_MAX_RST);
        send_vertex(32'h7FFF_FF00, 32'd0, 1'b1, 16'd7, 8'd1);
        send_vertex(32'h7FFF_FFC0, 32'd30, 1'b0, 16'd7, 8'd1);
        send_vertex(32'h7FFF_FFC0, 32'd30, 1'b0, 16'd7, 8'd1);

        // Largest spacing, no transect width, extreme coordinates.
        set_geometry(31'h7FFF_FFFF, 31'd0, pcsp_pkg::EXT_MIN_RST, pcsp_pkg::EXT_MAX_RST,
                     pcsp_pkg::EXT_MIN_RST, pcsp_pkg::EXT_MAX_RST);
        send_vertex(32'h8000_0000, 32'h0000_0000, 1'b1, 16'd8, 8'd2);
        send_vertex(32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 16'd8, 8'd2);
        send_vertex(32'h8000_0000, 32'h0000_0000, 1'b0, 16'd8, 8'd2);

        // Empty extent: no station can be inside.
        set_geometry(31'h0001_0000, 31'h0001_0000, 32'd1, 32'd0, 32'd1, 32'd0);
        send_vertex(32'd0, 32'd0, 1'b1, 16'd9, 8'd3);
        send_vertex(32'h0008_0000, 32'h0008_0000, 1'b0, 16'd9, 8'd3);

        // Random phases, each with its own geometry; one gets the long receiver hold-off.
        for (ph = 0; ph < 7; ph++) begin
            sp = $urandom_range(32'h0000_1000, 32'h0010_0000);
            if (ph % 3 == 1)
                set_geometry(31'(sp), 31'($urandom_range(0, 32'h0100_0000)), 32'hFFF0_0000,
                             32'h0010_0000, 32'hFFF0_0000, 32'h0010_0000);
            else
                set_geometry(31'(sp), 31'($urandom_range(0, 32'h0100_0000)),
                             pcsp_pkg::EXT_MIN_RST, pcsp_pkg::EXT_MAX_RST,
                             pcsp_pkg::EXT_MIN_RST, pcsp_pkg::EXT_MAX_RST);
            if (ph == 2) hold_go = 1'b1;
            if (ph == 6) no_idle <= 1'b1;
            while (vertices_sent < 40 + 40 * (ph + 1))
                random_part($urandom_range(2, 10), 6 * sp, 32'h0020_0000);
        end

        // Restore defaults and finish.
        set_geometry(pcsp_pkg::SPACING_RST, pcsp_pkg::HALF_LENGTH_RST, pcsp_pkg::EXT_MIN_RST,
                     pcsp_pkg::EXT_MAX_RST, pcsp_pkg::EXT_MIN_RST, pcsp_pkg::EXT_MAX_RST);
        random_part(6, 32'h0010_0000, 32'h0020_0000);
        vtx.valid <= 1'b0;
        drain();

        $display("Covered %0d vertices and %0d transects across %0d register settings.",
                 vertices_sent, transects, settings_used + 1);
        if (errors == 0)
            $display("PASS polyline_cross_section_placer");
        else
            $display("FAIL polyline_cross_section_placer");
        $finish;
    end
endmodule
